### rtl/core/afmv_pkg.sv
// ----------------------------------------------------------------------------
// afmv_pkg
// Shared types and constants for the affine matrix-vector apply unit: request
// codes, channel payloads, controller states and controller/datapath signals.
// ----------------------------------------------------------------------------
package afmv_pkg;

    localparam int DATA_W              = 32;
    localparam int IDX_W               = 6;
    localparam int CFG_W               = 7;
    localparam int ACC_W               = 48;
    localparam int VECTOR_SIZE_DEFAULT = 64;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    localparam logic [CFG_W-1:0] ACTIVE_SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        REQ_BASE   = 2'd0,
        REQ_OFFSET = 2'd1,
        REQ_MATRIX = 2'd2,
        REQ_APPLY  = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t                req_type;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [DATA_W-1:0] data_value;
        logic                     vector_end;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_index;
        logic signed [DATA_W-1:0] y_value;
        logic                     out_last;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MAC,
        ST_DRAIN,
        ST_OUT_RD,
        ST_OUT_CALC,
        ST_OUT_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic             load;
        logic             apply_start;
        logic             diff;
        logic             mac_issue;
        logic             out_issue;
        logic             out_load;
        logic             acc_clear;
        logic             last;
        logic [IDX_W-1:0] row;
    } dp_cmd_t;

    typedef struct packed {
        logic mac_busy;
    } dp_status_t;

endpackage

### rtl/core/afmv_ram.sv
// ----------------------------------------------------------------------------
// afmv_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module afmv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/afmv_ctrl.sv
// ----------------------------------------------------------------------------
// afmv_ctrl
// Controller: holds the active size register, sequences load, multiply-
// accumulate and output phases, and drives both channel handshakes.
// ----------------------------------------------------------------------------
module afmv_ctrl #(
    parameter int VECTOR_SIZE = afmv_pkg::VECTOR_SIZE_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  afmv_pkg::in_item_t          in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        cfg_we,
    input  logic [afmv_pkg::CFG_W-1:0]  cfg_data,
    output afmv_pkg::dp_cmd_t           cmd,
    input  afmv_pkg::dp_status_t        status
);

    localparam int SZ_W = afmv_pkg::CFG_W;
    localparam int IX_W = afmv_pkg::IDX_W;

    afmv_pkg::ctrl_state_t state_reg, state_next;
    logic [SZ_W-1:0] active_size_reg;
    logic [IX_W-1:0] row_reg, row_next;
    logic            end_reg, end_next;
    logic            skip_reg, skip_next;
    logic [SZ_W-1:0] live_size;
    logic [SZ_W-1:0] last_row;
    logic            row_last;

    // Out-of-range sizes are clamped: zero acts as one, oversize as the full store.
    always_comb
    begin
        if (active_size_reg == '0)
        begin
            live_size = SZ_W'(1);
        end
        else if (active_size_reg > SZ_W'(VECTOR_SIZE))
        begin
            live_size = SZ_W'(VECTOR_SIZE);
        end
        else
        begin
            live_size = active_size_reg;
        end
    end

    assign last_row = live_size - SZ_W'(1);
    assign row_last = (SZ_W'(row_reg) == last_row);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= afmv_pkg::ST_IDLE;
            active_size_reg <= afmv_pkg::ACTIVE_SIZE_RESET;
            row_reg         <= '0;
            end_reg         <= 1'b0;
            skip_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            end_reg   <= end_next;
            skip_reg  <= skip_next;
            if (cfg_we)
            begin
                active_size_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        row_next            = row_reg;
        end_next            = end_reg;
        skip_next           = skip_reg;
        in_stall            = 1'b1;
        out_valid           = 1'b0;
        cmd                 = '0;
        cmd.row             = row_reg;
        cmd.last            = row_last;

        unique case (state_reg)
            afmv_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (in_data.req_type == afmv_pkg::REQ_APPLY)
                    begin
                        cmd.apply_start = 1'b1;
                        end_next        = in_data.vector_end;
                        skip_next       = (SZ_W'(in_data.row_index) >= live_size);
                        state_next      = afmv_pkg::ST_DIFF;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end

            afmv_pkg::ST_DIFF:
            begin
                cmd.diff = 1'b1;
                row_next = '0;
                if (!skip_reg)
                begin
                    state_next = afmv_pkg::ST_MAC;
                end
                else if (end_reg)
                begin
                    state_next = afmv_pkg::ST_OUT_RD;
                end
                else
                begin
                    state_next = afmv_pkg::ST_IDLE;
                end
            end

            afmv_pkg::ST_MAC:
            begin
                cmd.mac_issue = 1'b1;
                if (row_last)
                begin
                    row_next   = '0;
                    state_next = afmv_pkg::ST_DRAIN;
                end
                else
                begin
                    row_next = row_reg + IX_W'(1);
                end
            end

            afmv_pkg::ST_DRAIN:
            begin
                // Wait for the last accumulator write-back before reading results or taking the next request.
                if (!status.mac_busy)
                begin
                    state_next = end_reg ? afmv_pkg::ST_OUT_RD : afmv_pkg::ST_IDLE;
                end
            end

            afmv_pkg::ST_OUT_RD:
            begin
                cmd.out_issue = 1'b1;
                state_next    = afmv_pkg::ST_OUT_CALC;
            end

            afmv_pkg::ST_OUT_CALC:
            begin
                cmd.out_load = 1'b1;
                state_next   = afmv_pkg::ST_OUT_HOLD;
            end

            afmv_pkg::ST_OUT_HOLD:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (row_last)
                    begin
                        cmd.acc_clear = 1'b1;
                        row_next      = '0;
                        state_next    = afmv_pkg::ST_IDLE;
                    end
                    else
                    begin
                        row_next   = row_reg + IX_W'(1);
                        state_next = afmv_pkg::ST_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = afmv_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/afmv_dp.sv
// ----------------------------------------------------------------------------
// afmv_dp
// Datapath: base, offset, matrix and accumulator memories, the difference
// register, one multiply-accumulate pipeline and the output register.
// ----------------------------------------------------------------------------
module afmv_dp #(
    parameter int VECTOR_SIZE = afmv_pkg::VECTOR_SIZE_DEFAULT,
    parameter int VALUE_WIDTH = afmv_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  afmv_pkg::in_item_t    in_data,
    input  afmv_pkg::dp_cmd_t     cmd,
    output afmv_pkg::dp_status_t  status,
    output afmv_pkg::out_item_t   out_data
);

    localparam int DW    = (VALUE_WIDTH < afmv_pkg::DATA_W) ? VALUE_WIDTH : afmv_pkg::DATA_W;
    localparam int DIW   = DW + 1;
    localparam int PW    = DIW + DW;
    localparam int SHW   = PW - 16;
    localparam int AW    = afmv_pkg::ACC_W;
    localparam int SUMW  = ((SHW > AW) ? SHW : AW) + 1;
    localparam int YW    = AW + 1;
    localparam int IW    = $clog2(VECTOR_SIZE);
    localparam int MAW   = 2 * IW;
    localparam int SZ_W  = afmv_pkg::CFG_W;
    localparam int OW    = afmv_pkg::DATA_W;

    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};
    localparam logic signed [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};

    logic              row_ok, col_ok;
    logic              base_we, off_we, mat_we;
    logic [IW-1:0]     in_row, in_col, cur_row;
    logic [DW-1:0]     in_val;
    logic [DW-1:0]     base_rd, off_rd, mat_rd;
    logic [AW-1:0]     acc_rd;

    logic signed [DW-1:0]   x_reg;
    logic [IW-1:0]          j_reg;
    logic signed [DIW-1:0]  d_reg;
    logic                   v1_reg, v2_reg;
    logic [IW-1:0]          idx1_reg, idx2_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [AW-1:0]   accq_reg;
    logic [VECTOR_SIZE-1:0] acc_valid_reg;
    afmv_pkg::out_item_t    out_reg;

    logic signed [SHW-1:0]  prod_sh;
    logic signed [SUMW-1:0] acc_sum;
    logic signed [AW-1:0]   acc_sat;
    logic signed [AW-1:0]   acc_cur;
    logic signed [YW-1:0]   y_sum;
    logic signed [DW-1:0]   y_sat;

    assign in_row  = in_data.row_index[IW-1:0];
    assign in_col  = in_data.col_index[IW-1:0];
    assign in_val  = in_data.data_value[DW-1:0];
    assign cur_row = cmd.row[IW-1:0];

    // Writes aimed beyond the stores are dropped.
    assign row_ok  = (SZ_W'(in_data.row_index) < SZ_W'(VECTOR_SIZE));
    assign col_ok  = (SZ_W'(in_data.col_index) < SZ_W'(VECTOR_SIZE));
    assign base_we = cmd.load && (in_data.req_type == afmv_pkg::REQ_BASE) && row_ok;
    assign off_we  = cmd.load && (in_data.req_type == afmv_pkg::REQ_OFFSET) && row_ok;
    assign mat_we  = cmd.load && (in_data.req_type == afmv_pkg::REQ_MATRIX) && row_ok && col_ok;

    afmv_ram #(.WIDTH(DW), .DEPTH(VECTOR_SIZE)) u_base_ram (
        .clk   (clk),
        .we    (base_we),
        .waddr (in_row),
        .wdata (in_val),
        .re    (cmd.apply_start),
        .raddr (in_row),
        .rdata (base_rd)
    );

    afmv_ram #(.WIDTH(DW), .DEPTH(VECTOR_SIZE)) u_offset_ram (
        .clk   (clk),
        .we    (off_we),
        .waddr (in_row),
        .wdata (in_val),
        .re    (cmd.out_issue),
        .raddr (cur_row),
        .rdata (off_rd)
    );

    // The matrix is kept column by column: the column selects the upper address bits.
    afmv_ram #(.WIDTH(DW), .DEPTH(1 << MAW)) u_matrix_ram (
        .clk   (clk),
        .we    (mat_we),
        .waddr ({in_col, in_row}),
        .wdata (in_val),
        .re    (cmd.mac_issue),
        .raddr ({j_reg, cur_row}),
        .rdata (mat_rd)
    );

    afmv_ram #(.WIDTH(AW), .DEPTH(VECTOR_SIZE)) u_acc_ram (
        .clk   (clk),
        .we    (v2_reg),
        .waddr (idx2_reg),
        .wdata (acc_sat),
        .re    (cmd.mac_issue || cmd.out_issue),
        .raddr (cur_row),
        .rdata (acc_rd)
    );

    // Shifting the exact product right rounds toward minus infinity.
    assign prod_sh = prod_reg[PW-1:16];
    assign acc_sum = SUMW'(accq_reg) + SUMW'(prod_sh);

    always_comb
    begin
        if ((&acc_sum[SUMW-1:AW-1]) || !(|acc_sum[SUMW-1:AW-1]))
        begin
            acc_sat = acc_sum[AW-1:0];
        end
        else if (acc_sum[SUMW-1])
        begin
            acc_sat = ACC_MIN;
        end
        else
        begin
            acc_sat = ACC_MAX;
        end
    end

    // An accumulator that has not been written since the last clear reads as zero.
    assign acc_cur = acc_valid_reg[cur_row] ? $signed(acc_rd) : '0;
    assign y_sum   = YW'($signed(off_rd)) + YW'(acc_cur);

    always_comb
    begin
        if ((&y_sum[YW-1:DW-1]) || !(|y_sum[YW-1:DW-1]))
        begin
            y_sat = y_sum[DW-1:0];
        end
        else if (y_sum[YW-1])
        begin
            y_sat = VAL_MIN;
        end
        else
        begin
            y_sat = VAL_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            acc_valid_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.mac_issue;
            v2_reg <= v1_reg;
            if (cmd.acc_clear)
            begin
                acc_valid_reg <= '0;
            end
            else if (v2_reg)
            begin
                acc_valid_reg[idx2_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply_start)
        begin
            x_reg <= $signed(in_val);
            j_reg <= in_row;
        end
        if (cmd.diff)
        begin
            d_reg <= DIW'(x_reg) - DIW'($signed(base_rd));
        end
        idx1_reg <= cur_row;
        idx2_reg <= idx1_reg;
        if (v1_reg)
        begin
            prod_reg <= PW'(d_reg) * PW'($signed(mat_rd));
            accq_reg <= acc_valid_reg[idx1_reg] ? $signed(acc_rd) : '0;
        end
        if (cmd.out_load)
        begin
            out_reg.out_index <= cmd.row;
            out_reg.y_value   <= OW'(y_sat);
            out_reg.out_last  <= cmd.last;
        end
    end

    assign status.mac_busy = v1_reg || v2_reg;
    assign out_data        = out_reg;

endmodule

### rtl/core/affine_matrix_vector_apply_unit.sv
// Load items (base, offset, matrix entry) are written while the controller stays idle.
// An x element on an active row walks the n active rows, one multiply-accumulate per
// cycle through the single matrix read port, then drains the v1 and v2 registers.
// Each result passes through OUT_RD, OUT_CALC and OUT_HOLD and is held while the output
// stalls; one item is worked at a time. Reset clears the accumulators at once through
// per-row valid bits and sets active_size to 64; base, offset and matrix stores are undefined until written.
// ----------------------------------------------------------------------------
// affine_matrix_vector_apply_unit
// Computes y = offset + P(x - base) in signed Q16.16 with a stored square
// matrix, one x element at a time, and streams out one result per row.
// ----------------------------------------------------------------------------
module affine_matrix_vector_apply_unit #(
    parameter int VECTOR_SIZE = afmv_pkg::VECTOR_SIZE_DEFAULT,
    parameter int VALUE_WIDTH = afmv_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  afmv_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_stall,
    output afmv_pkg::out_item_t        out_data,
    input  logic                       cfg_we,
    input  logic [afmv_pkg::CFG_W-1:0] cfg_data
);

    afmv_pkg::dp_cmd_t    cmd;
    afmv_pkg::dp_status_t status;

    afmv_ctrl #(
        .VECTOR_SIZE (VECTOR_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    afmv_dp #(
        .VECTOR_SIZE (VECTOR_SIZE),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cmd      (cmd),
        .status   (status),
        .out_data (out_data)
    );

endmodule

### bench/afmv_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afmv_result_checker
// Watches the request, result and register ports of the affine apply unit.
// It keeps its own copy of the base, offset and matrix stores and of the row
// accumulators, predicts every result vector and compares each result
// transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module afmv_result_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  afmv_pkg::in_item_t         in_data,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  afmv_pkg::out_item_t        out_data,
    input  logic                       cfg_we,
    input  logic [afmv_pkg::CFG_W-1:0] cfg_data,
    output int                         fail_total,
    output int                         pending_results
);

    localparam int     N_MAX  = afmv_pkg::VECTOR_SIZE_DEFAULT;
    localparam int     DATA_W = afmv_pkg::DATA_W;
    localparam int     ACC_W  = afmv_pkg::ACC_W;
    localparam int     CFG_W  = afmv_pkg::CFG_W;
    localparam int     IDX_W  = afmv_pkg::IDX_W;
    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint Y_HI   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Y_LO   = -Y_HI - 1;

    logic signed [DATA_W-1:0] base_mem   [N_MAX];
    logic signed [DATA_W-1:0] offset_mem [N_MAX];
    // Indexed [column][row], so one x element walks a single column.
    logic signed [DATA_W-1:0] coef_mem   [N_MAX][N_MAX];
    logic signed [ACC_W-1:0]  row_acc    [N_MAX];
    logic [CFG_W-1:0]         size_reg;
    afmv_pkg::out_item_t      expected_y [$];

    initial fail_total = 0;

    function automatic int rows_in_use(input logic [CFG_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > N_MAX)
            return N_MAX;
        return int'(s);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    task automatic predict_affine(input afmv_pkg::in_item_t req);
        int                  n;
        int                  i;
        longint              diff;
        longint              prod;
        longint              sum;
        afmv_pkg::out_item_t res;
        n = rows_in_use(size_reg);
        case (req.req_type)
            afmv_pkg::REQ_BASE:   base_mem[req.row_index] = req.data_value;
            afmv_pkg::REQ_OFFSET: offset_mem[req.row_index] = req.data_value;
            afmv_pkg::REQ_MATRIX: coef_mem[req.col_index][req.row_index] = req.data_value;
            default:
            begin
                if (int'(req.row_index) < n)
                begin
                    diff = longint'(req.data_value) - longint'(base_mem[req.row_index]);
                    for (i = 0; i < n; i++)
                    begin
                        // Arithmetic shift of the exact product rounds toward minus infinity.
                        prod = (diff * longint'(coef_mem[req.row_index][i])) >>> 16;
                        sum = longint'(row_acc[i]) + prod;
                        row_acc[i] = ACC_W'(clamp(sum, ACC_LO, ACC_HI));
                    end
                end
                if (req.vector_end)
                begin
                    for (i = 0; i < n; i++)
                    begin
                        sum = longint'(offset_mem[i]) + longint'(row_acc[i]);
                        res.out_index = IDX_W'(i);
                        res.y_value   = DATA_W'(clamp(sum, Y_LO, Y_HI));
                        res.out_last  = (i == n - 1);
                        expected_y = {expected_y, res};
                    end
                    for (i = 0; i < N_MAX; i++)
                        row_acc[i] = '0;
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        afmv_pkg::out_item_t want;
        if (!rst_n)
        begin
            size_reg = afmv_pkg::ACTIVE_SIZE_RESET;
            for (int i = 0; i < N_MAX; i++)
                row_acc[i] = '0;
            expected_y.delete();
            pending_results <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_y.size() == 0)
                begin
                    $error("unexpected result transfer: out_index %0d y_value %0d",
                           out_data.out_index, out_data.y_value);
                    fail_total++;
                end
                else
                begin
                    want = expected_y.pop_front();
                    if (out_data.out_index !== want.out_index)
                    begin
                        $error("out_index expected %0d actual %0d",
                               want.out_index, out_data.out_index);
                        fail_total++;
                    end
                    if (out_data.y_value !== want.y_value)
                    begin
                        $error("y_value expected %0d actual %0d",
                               want.y_value, out_data.y_value);
                        fail_total++;
                    end
                    if (out_data.out_last !== want.out_last)
                    begin
                        $error("out_last expected %0d actual %0d",
                               want.out_last, out_data.out_last);
                        fail_total++;
                    end
                end
            end
            if (cfg_we)
                size_reg = cfg_data;
            if (in_valid && !in_stall)
                predict_affine(in_data);
            pending_results <= expected_y.size();
        end
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the affine matrix-vector apply unit. Store entries
// are written just before an x element or a vector end first needs them. A
// directed pass covers extreme values, saturation, out-of-range sizes and
// inactive or repeated x elements, followed by random vectors under small
// active sizes with bursty requests and a stalling result receiver. The
// checker beside the block does all the comparing.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_CYCLES  = 100;
    localparam int ITEM_TARGET   = 100;
    localparam int SMALL_MAX     = 8;
    localparam int N_MAX         = afmv_pkg::VECTOR_SIZE_DEFAULT;
    localparam int DATA_W        = afmv_pkg::DATA_W;
    localparam int CFG_W         = afmv_pkg::CFG_W;
    localparam int IDX_W         = afmv_pkg::IDX_W;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                out_stall = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CFG_W-1:0]    cfg_data  = '0;
    afmv_pkg::in_item_t  in_data   = '0;
    logic                in_stall;
    logic                out_valid;
    afmv_pkg::out_item_t out_data;

    int fail_total;
    int pending_results;
    int burst_left  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    int stall_mode  = 0;
    int cur_rows    = N_MAX;
    int items_sent  = 0;

    // Entries already written; the matrix one is indexed [column][row].
    bit base_written   [N_MAX];
    bit offset_written [N_MAX];
    bit coef_written   [N_MAX][N_MAX];

    always #2 clk = ~clk;

    affine_matrix_vector_apply_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    afmv_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .fail_total      (fail_total),
        .pending_results (pending_results)
    );

    // The receiver switches between free running, random stalls and long stall runs.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 1) == 1);
            2:       out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ((stall_left % 24) < 18);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we))
            idle_cycles <= idle_cycles + 1;
        else
            idle_cycles <= 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly small Q16.16 values; wide_pct percent full-range or extreme ones.
    function automatic logic signed [DATA_W-1:0] rand_data(input int wide_pct);
        if ($urandom_range(0, 99) >= wide_pct)
            return DATA_W'($urandom_range(0, 262144)) - DATA_W'(131072);
        case ($urandom_range(0, 5))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic afmv_pkg::in_item_t make_req(input afmv_pkg::req_kind_t kind,
                                                    input int row, input int col,
                                                    input logic signed [DATA_W-1:0] val,
                                                    input logic last);
        afmv_pkg::in_item_t req;
        req.req_type   = kind;
        req.row_index  = IDX_W'(row);
        req.col_index  = IDX_W'(col);
        req.data_value = val;
        req.vector_end = last;
        return req;
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r == 9)
            return '0;
        return CFG_W'($urandom_range(1, SMALL_MAX));
    endfunction

    task automatic send_req(input afmv_pkg::in_item_t req);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 32);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_data  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        burst_left--;
        items_sent++;
        case (req.req_type)
            afmv_pkg::REQ_BASE:   base_written[req.row_index] = 1'b1;
            afmv_pkg::REQ_OFFSET: offset_written[req.row_index] = 1'b1;
            afmv_pkg::REQ_MATRIX: coef_written[req.col_index][req.row_index] = 1'b1;
            default:              ;
        endcase
    endtask

    // Holds the sender off until every predicted result has been transferred.
    task automatic drain_results(input int extra);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
        repeat (extra) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_size(input logic [CFG_W-1:0] s);
        drain_results(SETTLE_CYCLES);
        cfg_data <= s;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_rows = (s == 0) ? 1 : ((s > N_MAX) ? N_MAX : int'(s));
    endtask

    // Writes every entry that an x element on this row, and its vector end, will read.
    task automatic prepare_apply(input int row, input logic last);
        if (row < cur_rows)
        begin
            if (!base_written[row])
                send_req(make_req(afmv_pkg::REQ_BASE, row, 0, rand_data(5),
                                  1'($urandom_range(0, 1))));
            for (int r = 0; r < cur_rows; r++)
                if (!coef_written[row][r])
                    send_req(make_req(afmv_pkg::REQ_MATRIX, r, row, rand_data(5),
                                      1'($urandom_range(0, 1))));
        end
        if (last)
            for (int r = 0; r < cur_rows; r++)
                if (!offset_written[r])
                    send_req(make_req(afmv_pkg::REQ_OFFSET, r, $urandom_range(0, 63),
                                      rand_data(5), 1'($urandom_range(0, 1))));
    endtask

    task automatic send_apply(input int row, input logic signed [DATA_W-1:0] val,
                              input logic last);
        prepare_apply(row, last);
        send_req(make_req(afmv_pkg::REQ_APPLY, row, $urandom_range(0, 63), val, last));
    endtask

    task automatic send_random_load();
        send_req(make_req(afmv_pkg::req_kind_t'($urandom_range(0, 2)), $urandom_range(0, 63),
                          $urandom_range(0, 63), rand_data(40), 1'($urandom_range(0, 1))));
    endtask

    initial
    begin
        int len;
        int row;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Extreme x values and a repeated element.
        set_size(CFG_W'(4));
        send_apply(0, 32'sh7FFF_FFFF, 1'b0);
        send_apply(1, 32'sh8000_0000, 1'b0);
        send_apply(1, 32'sh8000_0000, 1'b0);
        send_apply(3, rand_data(0), 1'b1);

        // Loads carrying vector_end, then accumulator and output saturation upward.
        send_req(make_req(afmv_pkg::REQ_BASE, 2, 0, 32'sh8000_0000, 1'b1));
        send_req(make_req(afmv_pkg::REQ_MATRIX, 0, 2, 32'sh7FFF_FFFF, 1'b1));
        send_req(make_req(afmv_pkg::REQ_OFFSET, 0, 0, 32'sh7FFF_FFFF, 1'b1));
        send_apply(2, 32'sh7FFF_FFFF, 1'b0);
        send_apply(2, 32'sh7FFF_FFFF, 1'b1);

        // The same rows driven toward the negative limit.
        send_req(make_req(afmv_pkg::REQ_BASE, 2, 0, 32'sh7FFF_FFFF, 1'b0));
        send_req(make_req(afmv_pkg::REQ_OFFSET, 0, 0, 32'sh8000_0000, 1'b0));
        send_apply(2, 32'sh8000_0000, 1'b0);
        send_apply(2, 32'sh8000_0000, 1'b1);

        // Single row, then an x element beyond the active size that still ends a vector.
        set_size(CFG_W'(1));
        send_apply(0, rand_data(50), 1'b1);
        send_apply(40, rand_data(50), 1'b1);

        // A zero size folds to one row.
        set_size('0);
        send_apply(0, rand_data(50), 1'b1);

        // A size change inside a vector keeps the partial sums.
        set_size(CFG_W'(4));
        send_apply(0, rand_data(30), 1'b0);
        send_apply(3, rand_data(30), 1'b0);
        set_size(CFG_W'(2));
        send_apply(1, rand_data(30), 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            if ($urandom_range(0, 3) == 0)
                set_size(pick_size());
            len = $urandom_range(1, cur_rows + 2);
            for (int e = 0; e < len; e++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_random_load();
                row = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, cur_rows - 1);
                send_apply(row, rand_data(30),
                           (e == len - 1) || ($urandom_range(0, 11) == 0));
            end
        end

        drain_results(DRAIN_CYCLES);
        if (fail_total == 0 && pending_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
